// ----- hdl/qihp_pkg.sv -----
package qihp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VER_W   = 32;

	// Reset value of the connection ID length limit.
	localparam logic [BYTE_W-1:0] MAX_ID_LEN_RESET = 8'd20;

	// First byte: long header needs both top bits set, Initial needs bits 5:4 clear.
	localparam logic [BYTE_W-1:0] FORM_MASK  = 8'hc0;
	localparam logic [BYTE_W-1:0] TYPE_MASK  = 8'h30;
	localparam logic [BYTE_W-1:0] TYPE_INIT  = 8'h00;

	// Number of version bytes.
	localparam logic [BYTE_W-1:0] VERSION_BYTES = 8'd4;

	typedef enum logic [2:0] {
		PH_FIRST      = 3'd0,
		PH_VERSION    = 3'd1,
		PH_DCID_LEN   = 3'd2,
		PH_DCID_BYTES = 3'd3,
		PH_SCID_LEN   = 3'd4,
		PH_SCID_BYTES = 3'd5,
		PH_IGNORE     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_MATCH  = 2'd1,
		ST_NEED_MORE = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic              id_byte_valid;
		logic              id_select;
		logic [BYTE_W-1:0] id_index;
		logic [BYTE_W-1:0] id_value;
		logic              done_res;
		status_t           status;
		logic [VER_W-1:0]  version;
	} out_item_t;

endpackage

// ----- hdl/qihp_in_stage.sv -----
module qihp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qihp_pkg::in_item_t in_item,
	input  logic               advance,
	output logic               valid_s1,
	output qihp_pkg::in_item_t item_s1
);
	import qihp_pkg::*;

	// The stage takes a new item when it is empty or its item moves on now.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- hdl/qihp_core.sv -----
module qihp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  qihp_pkg::in_item_t          item,
	input  logic [qihp_pkg::BYTE_W-1:0] max_id_length,
	output logic                        res_present,
	output qihp_pkg::out_item_t         res
);
	import qihp_pkg::*;

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  byte_cnt_q, byte_cnt_d;
	logic [VER_W-1:0]   version_q, version_d;
	logic [BYTE_W-1:0]  id_pos_q, id_pos_d;

	logic               idv, sel, decided, active;
	logic [BYTE_W-1:0]  idx, b, cnt_inc;
	status_t            st;

	assign b = item.data_byte;
	assign cnt_inc = byte_cnt_q + 8'd1;

	always_comb begin
		phase_d    = phase_q;
		byte_cnt_d = byte_cnt_q;
		version_d  = version_q;
		id_pos_d   = id_pos_q;
		idv        = 1'b0;
		sel        = 1'b0;
		idx        = '0;
		decided    = 1'b0;
		st         = ST_OK;
		active     = 1'b1;
		case (phase_q)
			PH_FIRST: begin
				if ((b & FORM_MASK) != FORM_MASK || (b & TYPE_MASK) != TYPE_INIT) begin
					decided = 1'b1;
					st      = ST_NO_MATCH;
				end else begin
					phase_d    = PH_VERSION;
					byte_cnt_d = '0;
					version_d  = '0;
				end
			end
			PH_VERSION: begin
				version_d  = {version_q[VER_W-BYTE_W-1:0], b};
				byte_cnt_d = cnt_inc;
				if (cnt_inc >= VERSION_BYTES) begin
					if (version_d == '0) begin
						decided = 1'b1;
						st      = ST_NO_MATCH;
					end else begin
						phase_d = PH_DCID_LEN;
					end
				end
			end
			PH_DCID_LEN, PH_SCID_LEN: begin
				if (b > max_id_length) begin
					decided = 1'b1;
					st      = ST_MALFORMED;
				end else if (b == '0) begin
					if (phase_q == PH_DCID_LEN) begin
						phase_d = PH_SCID_LEN;
					end else begin
						decided = 1'b1;
						st      = ST_OK;
					end
				end else begin
					byte_cnt_d = b;
					id_pos_d   = '0;
					phase_d    = (phase_q == PH_DCID_LEN) ? PH_DCID_BYTES : PH_SCID_BYTES;
				end
			end
			PH_DCID_BYTES, PH_SCID_BYTES: begin
				idv        = 1'b1;
				sel        = (phase_q == PH_SCID_BYTES);
				idx        = id_pos_q;
				id_pos_d   = id_pos_q + 8'd1;
				byte_cnt_d = byte_cnt_q - 8'd1;
				if (byte_cnt_d == '0) begin
					if (phase_q == PH_DCID_BYTES) begin
						phase_d = PH_SCID_LEN;
					end else begin
						decided = 1'b1;
						st      = ST_OK;
					end
				end
			end
			default: begin
				// Ignore phase: wait for the end of the datagram.
				active = 1'b0;
			end
		endcase

		// A datagram that ends before a decision is short.
		if (!decided && item.last_byte && active) begin
			decided = 1'b1;
			st      = ST_NEED_MORE;
		end
		if (decided) begin
			phase_d = item.last_byte ? PH_FIRST : PH_IGNORE;
		end else if (item.last_byte) begin
			phase_d = PH_FIRST;
		end
	end

	always_comb begin
		res_present       = idv || decided;
		res.id_byte_valid = idv;
		res.id_select     = sel;
		res.id_index      = idx;
		res.id_value      = idv ? b : '0;
		res.done_res      = decided;
		res.status        = decided ? st : ST_OK;
		res.version       = (decided && st == ST_OK) ? version_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			byte_cnt_q <= '0;
			version_q  <= '0;
			id_pos_q   <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			byte_cnt_q <= byte_cnt_d;
			version_q  <= version_d;
			id_pos_q   <= id_pos_d;
		end
	end

endmodule

// ----- hdl/quic_initial_header_parser.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_item  (one datagram byte, last flag)
// out     | output    | out_valid / out_ready | out_item (ID byte and/or final status)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (connection ID length limit)
//
// One item is accepted per cycle while the input register is empty or its item moves on.
// An accepted item waits in the input register; its result is loaded into the result
// register when the item advances, and is offered from there until it is taken.
// The phase update of one byte is the only loop.
// Reset clears the parser to wait for a first byte and sets the limit to 20.
// A stalled output holds its result while the input register keeps one more item;
// after that, in_ready falls until the result is taken.
module quic_initial_header_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  qihp_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output qihp_pkg::out_item_t         out_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [qihp_pkg::BYTE_W-1:0] cfg_data
);
	import qihp_pkg::*;

	logic              valid_s1;
	in_item_t          item_s1;
	logic              advance;
	logic              res_present;
	out_item_t         res;
	logic [BYTE_W-1:0] max_id_len_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	// The limit register is always writable; the user must change it only while the parser is idle (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_id_len_q <= MAX_ID_LEN_RESET;
		end else if (cfg_valid) begin
			max_id_len_q <= cfg_data;
		end
	end

	// The held item is parsed when the result register is empty or being emptied.
	// Items that cause no result still advance and update the parser state.
	assign advance = valid_s1 && (!out_valid_q || out_ready);

	qihp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	qihp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.max_id_length (max_id_len_q),
		.res_present   (res_present),
		.res           (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_present;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Every result delivered carries an ID byte, a status, or both.
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.id_byte_valid || out_item.done_res))
		else $error("result item carries neither ID byte nor status");

	// The version word is reported only with an ok status.
	a_version_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status != ST_OK) |-> out_item.version == '0)
		else $error("version reported with a failing status");

	// Input back-pressure only appears when the input register is occupied.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a full pipeline");

	// A result that is not taken holds on to its item in the input register.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && valid_s1) |=> valid_s1)
		else $error("held item lost during output stall");

endmodule
